/* rtl/streaming_pattern_matcher_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the streaming pattern matcher
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef STREAMING_PATTERN_MATCHER_ASSERT_SVH
`define STREAMING_PATTERN_MATCHER_ASSERT_SVH

// consequent checked in the same cycle
`define SPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spm assertion failed");

// consequent checked in the cycle after the antecedent
`define SPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spm assertion failed");

`endif

/* rtl/spm_pkg.sv */
// ---------------------------------------------------------------------------
// spm_pkg
// Word types, request codes and cell control for the pattern matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

	localparam int MATCH_INDEX_W = 16;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_TEXT   = 2'd2;
	localparam logic [1:0] REQ_END    = 2'd3;

	localparam logic RES_MATCH     = 1'b0;
	localparam logic RES_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic                     result_kind;
		logic [MATCH_INDEX_W-1:0] match_index;
	} res_t;

	typedef struct packed {
		logic shift_text;
		logic shift_pat;
		logic clear;
	} spm_ctl_t;

endpackage

`default_nettype wire

/* rtl/streaming_pattern_matcher.sv */
// ---------------------------------------------------------------------------
// streaming_pattern_matcher
// Exact byte pattern search over a text stream using a row of compare cells.
// ---------------------------------------------------------------------------
//
//  channel  valid      stall      word   contents
//  request  req_valid  req_stall  req    req_type, data_byte
//  result   res_valid  res_stall  res    result_kind, match_index
//
// One word per cycle in while req_stall is low; each word is compared and
// registered in the s1 stage, then a result, if any, in the result register.
// Pattern and text shift through the cell row in the accept cycle, so
// appends and text bytes may follow each other every cycle.
// res_stall holds the result register; the compare stage still takes one
// more word if it is empty, then req_stall rises. No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "streaming_pattern_matcher_assert.svh"

module streaming_pattern_matcher
	import spm_pkg::*;
#(
	parameter int PATTERN_MAX = 64,
	parameter int INDEX_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CMP_W = INDEX_BITS + LEN_W;

	logic       accept;
	logic       adv;
	spm_ctl_t   ctl;

	logic [7:0]             text_ch [PATTERN_MAX];
	logic [7:0]             pat_ch  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] pv_ch;
	logic [PATTERN_MAX-1:0] pv_vec;
	logic [PATTERN_MAX-1:0] ok_vec;

	logic [LEN_W-1:0]      len_q;
	logic [INDEX_BITS-1:0] pos_q;
	logic [INDEX_BITS-1:0] pos_inc;
	logic [CMP_W-1:0]      start_wide;

	logic                   valid_s1;
	logic [1:0]             kind_s1;
	logic [PATTERN_MAX-1:0] ok_s1;
	logic                   len_zero_s1;
	logic                   long_enough_s1;
	logic [INDEX_BITS-1:0]  before_s1;
	logic [INDEX_BITS-1:0]  start_s1;

	logic                   res_valid_q;
	res_t                   res_q;
	logic                   found_q;

	logic                   emit;
	logic                   emit_kind;
	logic [INDEX_BITS-1:0]  emit_idx;
	logic                   found_next;
	logic [INDEX_BITS+MATCH_INDEX_W-1:0] idx_ext;

	// handshake
	assign adv       = !res_valid_q || !res_stall;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	assign ctl.shift_text = accept && (req.req_type == REQ_TEXT);
	assign ctl.shift_pat  = accept && (req.req_type == REQ_APPEND) &&
	                        (len_q < LEN_W'(PATTERN_MAX));
	assign ctl.clear      = accept && (req.req_type == REQ_CLEAR);

	// cell row: newest byte enters at cell 0
	assign text_ch[0] = req.data_byte;
	assign pat_ch[0]  = req.data_byte;
	assign pv_ch[0]   = 1'b1;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		if (k < PATTERN_MAX - 1) begin : g_mid
			spm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.text_in  (text_ch[k]),
				.pat_in   (pat_ch[k]),
				.pv_in    (pv_ch[k]),
				.text_out (text_ch[k+1]),
				.pat_out  (pat_ch[k+1]),
				.pv_out   (pv_vec[k]),
				.ok       (ok_vec[k])
			);
			assign pv_ch[k+1] = pv_vec[k];
		end else begin : g_last
			spm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.text_in  (text_ch[k]),
				.pat_in   (pat_ch[k]),
				.pv_in    (pv_ch[k]),
				.text_out (),
				.pat_out  (),
				.pv_out   (pv_vec[k]),
				.ok       (ok_vec[k])
			);
		end
	end

	// text count, saturating
	assign pos_inc    = (pos_q == {INDEX_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
	assign start_wide = CMP_W'(pos_inc) - CMP_W'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				case (req.req_type)
					REQ_CLEAR: begin
						len_q <= '0;
						pos_q <= '0;
					end
					REQ_APPEND: begin
						if (len_q < LEN_W'(PATTERN_MAX)) begin
							len_q <= len_q + 1'b1;
						end
					end
					REQ_TEXT: begin
						pos_q <= pos_inc;
					end
					REQ_END: begin
						pos_q <= '0;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1        <= req.req_type;
			ok_s1          <= ok_vec;
			len_zero_s1    <= (len_q == '0);
			long_enough_s1 <= (CMP_W'(pos_inc) >= CMP_W'(len_q));
			before_s1      <= pos_q;
			start_s1       <= start_wide[INDEX_BITS-1:0];
		end
	end

	// result decision, in word order
	always_comb begin
		emit       = 1'b0;
		emit_kind  = RES_MATCH;
		emit_idx   = before_s1;
		found_next = found_q;
		case (kind_s1)
			REQ_CLEAR: begin
				found_next = 1'b0;
			end
			REQ_APPEND: begin
				found_next = found_q;
			end
			REQ_TEXT: begin
				if (len_zero_s1) begin
					emit       = 1'b1;
					found_next = 1'b1;
				end else if (long_enough_s1 && (&ok_s1)) begin
					emit       = 1'b1;
					emit_idx   = start_s1;
					found_next = 1'b1;
				end
			end
			REQ_END: begin
				if (len_zero_s1) begin
					emit = 1'b1;
				end else if (!found_q) begin
					emit      = 1'b1;
					emit_kind = RES_NOT_FOUND;
					emit_idx  = '0;
				end
				found_next = 1'b0;
			end
			default: begin
				found_next = found_q;
			end
		endcase
	end

	assign idx_ext = {{MATCH_INDEX_W{1'b0}}, emit_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				found_q <= found_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			res_q.result_kind <= emit_kind;
			res_q.match_index <= idx_ext[MATCH_INDEX_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SPM_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(PATTERN_MAX))
	`SPM_ASSERT_NOW(a_pv_len, 1'b1, $countones(pv_vec) == int'(len_q))
	`SPM_ASSERT_NEXT(a_clear_len, accept && (req.req_type == REQ_CLEAR), len_q == '0)
	`SPM_ASSERT_NOW(a_nf_zero, res_valid_q && (res_q.result_kind == RES_NOT_FOUND),
		res_q.match_index == '0)

endmodule

`default_nettype wire

/* rtl/spm_cell.sv */
// ---------------------------------------------------------------------------
// spm_cell
// One window position: a text byte, the pattern byte aligned to it and a
// flag that the pattern reaches this far. Compares the incoming text byte.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_cell
	import spm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire spm_ctl_t   ctl,
	input  wire logic [7:0] text_in,
	input  wire logic [7:0] pat_in,
	input  wire logic       pv_in,
	output logic      [7:0] text_out,
	output logic      [7:0] pat_out,
	output logic            pv_out,
	output logic            ok
);

	logic [7:0] win_q;
	logic [7:0] pat_q;
	logic       pv_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_text) begin
			win_q <= text_in;
		end
		if (ctl.shift_pat) begin
			pat_q <= pat_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (ctl.clear) begin
			pv_q <= 1'b0;
		end else if (ctl.shift_pat) begin
			pv_q <= pv_in;
		end
	end

	// text_in is the byte this cell holds once the shift lands
	assign ok       = !pv_q || (text_in == pat_q);
	assign text_out = win_q;
	assign pat_out  = pat_q;
	assign pv_out   = pv_q;

endmodule

`default_nettype wire
